// ===== sv/ifscg_pkg.sv =====
package ifscg_pkg;

   localparam int WORD_BITS      = 32;
   localparam int MAP_BITS       = 2;
   localparam int SCALE_BITS     = 8;
   localparam int ORIGIN_BITS    = 10;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 10;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRACTAL_SELECT = 2'd0,
      CSR_PIXEL_SCALE    = 2'd1,
      CSR_X_ORIGIN       = 2'd2,
      CSR_Y_ORIGIN       = 2'd3
   } csr_index_type;

   localparam logic                   FRACTAL_SELECT_RESET = 1'b1;
   localparam logic [SCALE_BITS-1:0]  PIXEL_SCALE_RESET    = 8'd60;
   localparam logic [ORIGIN_BITS-1:0] X_ORIGIN_RESET       = 10'd400;
   localparam logic [ORIGIN_BITS-1:0] Y_ORIGIN_RESET       = 10'd600;

   typedef struct packed {
      logic                   fractal_select;
      logic [SCALE_BITS-1:0]  pixel_scale;
      logic [ORIGIN_BITS-1:0] x_origin;
      logic [ORIGIN_BITS-1:0] y_origin;
   } cfg_type;

   typedef enum logic [2:0] {
      OPA_A,
      OPA_B,
      OPA_C,
      OPA_D,
      OPA_SCALE
   } opa_sel_type;

   typedef enum logic {
      OPB_X,
      OPB_Y
   } opb_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_HALF,
      ACC_ADD,
      ACC_LOAD_XPIX,
      ACC_LOAD_YPIX
   } acc_op_type;

   typedef enum logic [2:0] {
      WB_NONE,
      WB_X,
      WB_Y,
      WB_PIX_X,
      WB_PIX_Y
   } wb_sel_type;

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_WAIT_REQ,
      BR_WAIT_RSP
   } branch_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_AX,
      ST_MUL_BY,
      ST_MUL_CX,
      ST_MUL_DY,
      ST_SCALE_X,
      ST_NEW_Y,
      ST_SCALE_Y,
      ST_PIX_Y_ACC,
      ST_DELIVER
   } step_type;

   typedef struct packed {
      opa_sel_type opa;
      opb_sel_type opb;
      acc_op_type  acc_op;
      wb_sel_type  wb;
      branch_type  branch;
      step_type    target;
   } ucode_word_type;

   typedef struct packed {
      ucode_word_type word;
      logic           fire;
   } seq_ctl_type;

   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type w;
      unique case (step)
         ST_IDLE:      w = '{OPA_A,     OPB_X, ACC_HOLD,      WB_NONE,  BR_WAIT_REQ, ST_MUL_AX};
         ST_MUL_AX:    w = '{OPA_A,     OPB_X, ACC_HOLD,      WB_NONE,  BR_NEXT,     ST_MUL_BY};
         ST_MUL_BY:    w = '{OPA_B,     OPB_Y, ACC_LOAD_HALF, WB_NONE,  BR_NEXT,     ST_MUL_CX};
         ST_MUL_CX:    w = '{OPA_C,     OPB_X, ACC_ADD,       WB_NONE,  BR_NEXT,     ST_MUL_DY};
         ST_MUL_DY:    w = '{OPA_D,     OPB_Y, ACC_LOAD_HALF, WB_X,     BR_NEXT,     ST_SCALE_X};
         ST_SCALE_X:   w = '{OPA_SCALE, OPB_X, ACC_ADD,       WB_NONE,  BR_NEXT,     ST_NEW_Y};
         ST_NEW_Y:     w = '{OPA_SCALE, OPB_X, ACC_LOAD_XPIX, WB_Y,     BR_NEXT,     ST_SCALE_Y};
         ST_SCALE_Y:   w = '{OPA_SCALE, OPB_Y, ACC_HOLD,      WB_PIX_X, BR_NEXT,     ST_PIX_Y_ACC};
         ST_PIX_Y_ACC: w = '{OPA_SCALE, OPB_Y, ACC_LOAD_YPIX, WB_NONE,  BR_NEXT,     ST_DELIVER};
         ST_DELIVER:   w = '{OPA_SCALE, OPB_Y, ACC_HOLD,      WB_PIX_Y, BR_WAIT_RSP, ST_IDLE};
         default:      w = '{OPA_A,     OPB_X, ACC_HOLD,      WB_NONE,  BR_NEXT,     ST_IDLE};
      endcase
      return w;
   endfunction

   function automatic longint qc(input longint n, input int frac_bits);
      return ((n <<< frac_bits) + 64'sd5000) / 64'sd10000;
   endfunction

   function automatic longint unsigned thr(input longint unsigned n);
      return (n * 64'hFFFF_FFFF + 64'd9999) / 64'd10000;
   endfunction

   localparam logic [WORD_BITS-1:0] FERN_THR_0 = WORD_BITS'(thr(64'd100));
   localparam logic [WORD_BITS-1:0] FERN_THR_1 = WORD_BITS'(thr(64'd8600));
   localparam logic [WORD_BITS-1:0] FERN_THR_2 = WORD_BITS'(thr(64'd9300));
   localparam logic [WORD_BITS-1:0] TRI_THR_0  = WORD_BITS'(thr(64'd3333));
   localparam logic [WORD_BITS-1:0] TRI_THR_1  = WORD_BITS'(thr(64'd6666));

   function automatic logic [MAP_BITS-1:0] select_map(input logic [WORD_BITS-1:0] w,
                                                      input logic fern);
      logic [MAP_BITS-1:0] k;
      k = 2'd0;
      if (fern) begin
         if (w >= FERN_THR_2) k = 2'd3;
         else if (w >= FERN_THR_1) k = 2'd2;
         else if (w >= FERN_THR_0) k = 2'd1;
      end else begin
         if (w >= TRI_THR_1) k = 2'd2;
         else if (w >= TRI_THR_0) k = 2'd1;
      end
      return k;
   endfunction

endpackage

// ===== sv/ifscg_if.sv =====
interface ifscg_req_if
   import ifscg_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink (input valid, input random_word, output ready);
endinterface

interface ifscg_rsp_if
   import ifscg_pkg::*;
   #(parameter int SCREEN_BITS = 10)
   ();
   logic                   valid;
   logic                   ready;
   logic [SCREEN_BITS-1:0] pixel_x;
   logic [SCREEN_BITS-1:0] pixel_y;
   logic [MAP_BITS-1:0]    map_chosen;
   logic                   clipped;

   modport source (output valid, output pixel_x, output pixel_y, output map_chosen,
                   output clipped, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, input map_chosen,
                 input clipped, output ready);
endinterface

// ===== sv/ifscg_sequencer.sv =====
module ifscg_sequencer
   import ifscg_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        rsp_busy,
   output logic        req_ready,
   output seq_ctl_type seq
);

   step_type       step_ff;
   step_type       step_in;
   ucode_word_type word;
   logic           go;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      word = ucode_rom(step_ff);
      unique case (word.branch)
         BR_NEXT:     go = 1'b1;
         BR_WAIT_REQ: go = req_valid;
         BR_WAIT_RSP: go = !rsp_busy;
         default:     go = 1'b0;
      endcase
      step_in   = go ? word.target : step_ff;
      req_ready = (word.branch == BR_WAIT_REQ);
      seq.word  = word;
      seq.fire  = go;
   end

endmodule

// ===== sv/ifscg_datapath.sv =====
module ifscg_datapath
   import ifscg_pkg::*;
   #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int SCREEN_BITS     = 10
   ) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  seq_ctl_type            seq,
   input  logic [WORD_BITS-1:0]   random_word,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [SCREEN_BITS-1:0] pixel_x,
   output logic [SCREEN_BITS-1:0] pixel_y,
   output logic [MAP_BITS-1:0]    map_chosen,
   output logic                   clipped
);

   localparam int F    = COORD_FRAC_BITS;
   localparam int CW   = F + 8;
   localparam int KW   = F + 2;
   localparam int PW   = KW + CW;
   localparam int AW   = 2 * F + 12;
   localparam int SW   = AW - F;
   localparam int SUMW = SW + 1;

   localparam logic signed [KW-1:0] K_016 = KW'(qc(64'sd1600, F));
   localparam logic signed [KW-1:0] K_085 = KW'(qc(64'sd8500, F));
   localparam logic signed [KW-1:0] K_004 = KW'(qc(64'sd400, F));
   localparam logic signed [KW-1:0] K_020 = KW'(qc(64'sd2000, F));
   localparam logic signed [KW-1:0] K_026 = KW'(qc(64'sd2600, F));
   localparam logic signed [KW-1:0] K_023 = KW'(qc(64'sd2300, F));
   localparam logic signed [KW-1:0] K_022 = KW'(qc(64'sd2200, F));
   localparam logic signed [KW-1:0] K_015 = KW'(qc(64'sd1500, F));
   localparam logic signed [KW-1:0] K_028 = KW'(qc(64'sd2800, F));
   localparam logic signed [KW-1:0] K_024 = KW'(qc(64'sd2400, F));
   localparam logic signed [KW-1:0] K_050 = KW'(qc(64'sd5000, F));
   localparam logic signed [CW-1:0] O_160 = CW'(qc(64'sd16000, F));
   localparam logic signed [CW-1:0] O_044 = CW'(qc(64'sd4400, F));
   localparam logic signed [CW-1:0] O_500 = CW'(qc(64'sd50000, F));
   localparam logic signed [CW-1:0] O_288 = CW'(qc(64'sd28850, F));

   localparam logic signed [AW-1:0]   HALF = AW'(64'sd1 <<< (F - 1));
   localparam logic signed [SUMW-1:0] CMAX = SUMW'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [SUMW-1:0] CMIN = SUMW'(-(64'sd1 <<< (CW - 1)));
   localparam logic signed [SW-1:0]   PMAX = SW'((64'sd1 <<< SCREEN_BITS) - 64'sd1);

   logic signed [CW-1:0]      cur_x_ff, cur_x_in;
   logic signed [CW-1:0]      cur_y_ff, cur_y_in;
   logic [MAP_BITS-1:0]       map_ff;
   logic signed [PW-1:0]      prod_ff, prod_in;
   logic signed [AW-1:0]      acc_ff, acc_in;
   logic [SCREEN_BITS-1:0]    px_ff;
   logic                      clip_x_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SCREEN_BITS-1:0]    rsp_x_ff;
   logic [SCREEN_BITS-1:0]    rsp_y_ff;
   logic [MAP_BITS-1:0]       rsp_map_ff;
   logic                      rsp_clip_ff;

   logic signed [KW-1:0]      coef_a, coef_b, coef_c, coef_d;
   logic signed [CW-1:0]      off_e, off_f, off_sel;
   logic signed [KW-1:0]      opa_val;
   logic signed [CW-1:0]      opb_val;
   logic signed [AW-1:0]      prod_ext, x_org, y_org;
   logic signed [SW-1:0]      acc_sh;
   logic signed [SUMW-1:0]    coord_sum;
   logic signed [CW-1:0]      coord_sat;
   logic [SCREEN_BITS-1:0]    pix_val;
   logic                      pix_clip;
   logic                      accept;

   assign accept = seq.fire && (seq.word.branch == BR_WAIT_REQ);

   always_comb begin
      coef_a = '0;
      coef_b = '0;
      coef_c = '0;
      coef_d = '0;
      off_e  = '0;
      off_f  = '0;
      if (cfg.fractal_select) begin
         unique case (map_ff)
            2'd0: begin
               coef_d = K_016;
            end
            2'd1: begin
               coef_a = K_085;
               coef_b = K_004;
               coef_c = -K_004;
               coef_d = K_085;
               off_f  = O_160;
            end
            2'd2: begin
               coef_a = K_020;
               coef_b = -K_026;
               coef_c = K_023;
               coef_d = K_022;
               off_f  = O_160;
            end
            default: begin
               coef_a = -K_015;
               coef_b = K_028;
               coef_c = K_026;
               coef_d = K_024;
               off_f  = O_044;
            end
         endcase
      end else begin
         coef_a = K_050;
         coef_d = K_050;
         unique case (map_ff)
            2'd1:    off_e = -O_288;
            2'd2:    off_e = O_288;
            default: off_f = O_500;
         endcase
      end
   end

   always_comb begin
      unique case (seq.word.opa)
         OPA_A:     opa_val = coef_a;
         OPA_B:     opa_val = coef_b;
         OPA_C:     opa_val = coef_c;
         OPA_D:     opa_val = coef_d;
         OPA_SCALE: opa_val = signed'(KW'(cfg.pixel_scale));
         default:   opa_val = '0;
      endcase
      opb_val = (seq.word.opb == OPB_Y) ? cur_y_ff : cur_x_ff;
      prod_in = opa_val * opb_val;
   end

   always_comb begin
      prod_ext = AW'(prod_ff);
      x_org    = signed'(AW'(cfg.x_origin)) <<< F;
      y_org    = signed'(AW'(cfg.y_origin)) <<< F;
      unique case (seq.word.acc_op)
         ACC_HOLD:      acc_in = acc_ff;
         ACC_LOAD_HALF: acc_in = HALF + prod_ext;
         ACC_ADD:       acc_in = acc_ff + prod_ext;
         ACC_LOAD_XPIX: acc_in = x_org + HALF + prod_ext;
         ACC_LOAD_YPIX: acc_in = y_org + HALF - prod_ext;
         default:       acc_in = acc_ff;
      endcase
   end

   always_comb begin
      acc_sh    = SW'(acc_ff >>> F);
      off_sel   = (seq.word.wb == WB_Y) ? off_f : off_e;
      coord_sum = SUMW'(acc_sh) + SUMW'(off_sel);
      if (coord_sum > CMAX) begin
         coord_sat = CW'(CMAX);
      end else if (coord_sum < CMIN) begin
         coord_sat = CW'(CMIN);
      end else begin
         coord_sat = CW'(coord_sum);
      end
      if (acc_sh < 0) begin
         pix_val  = '0;
         pix_clip = 1'b1;
      end else if (acc_sh > PMAX) begin
         pix_val  = '1;
         pix_clip = 1'b1;
      end else begin
         pix_val  = SCREEN_BITS'(acc_sh);
         pix_clip = 1'b0;
      end
   end

   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (seq.fire && seq.word.wb == WB_X) cur_x_in = coord_sat;
      if (seq.fire && seq.word.wb == WB_Y) cur_y_in = coord_sat;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (seq.fire && seq.word.wb == WB_PIX_Y) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (seq.fire) begin
         acc_ff <= acc_in;
      end
      if (accept) begin
         map_ff <= select_map(random_word, cfg.fractal_select);
      end
      if (seq.fire && seq.word.wb == WB_PIX_X) begin
         px_ff     <= pix_val;
         clip_x_ff <= pix_clip;
      end
      if (seq.fire && seq.word.wb == WB_PIX_Y) begin
         rsp_x_ff    <= px_ff;
         rsp_y_ff    <= pix_val;
         rsp_map_ff  <= map_ff;
         rsp_clip_ff <= clip_x_ff | pix_clip;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign pixel_x    = rsp_x_ff;
   assign pixel_y    = rsp_y_ff;
   assign map_chosen = rsp_map_ff;
   assign clipped    = rsp_clip_ff;

endmodule

// ===== sv/ifs_chaos_game_point_step_unit.sv =====
// Chaos-game point step for a Barnsley fern or a Sierpinski triangle: each request carries one
// random word that picks an affine map, the map moves the stored point, and the response gives
// the new point as a clamped screen pixel with the map index and a clipped flag. A request
// is taken only while the program waits in its first step, so none is taken until the last
// has run through all steps, because a ten-step control program drives one shared multiplier
// through the six products of each step. The finished response waits in an output register,
// so the next request is accepted and worked on while it waits; the program holds only in its
// last step if the previous response has still not been taken. Configuration writes are meant
// to arrive while no request is in progress.
module ifs_chaos_game_point_step_unit
   import ifscg_pkg::*;
   #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int SCREEN_BITS     = 10
   ) (
   input  logic                      clock,
   input  logic                      reset,
   ifscg_req_if.sink                 req_bus,
   ifscg_rsp_if.source               rsp_bus,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   cfg_type     cfg_ff, cfg_in;
   seq_ctl_type seq;
   logic        rsp_busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRACTAL_SELECT: cfg_in.fractal_select = csr_write_data[0];
            CSR_PIXEL_SCALE:    cfg_in.pixel_scale    = csr_write_data[SCALE_BITS-1:0];
            CSR_X_ORIGIN:       cfg_in.x_origin       = csr_write_data[ORIGIN_BITS-1:0];
            CSR_Y_ORIGIN:       cfg_in.y_origin       = csr_write_data[ORIGIN_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{FRACTAL_SELECT_RESET, PIXEL_SCALE_RESET, X_ORIGIN_RESET, Y_ORIGIN_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign rsp_busy = rsp_bus.valid && !rsp_bus.ready;

   ifscg_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .rsp_busy  (rsp_busy),
      .req_ready (req_bus.ready),
      .seq       (seq)
   );

   ifscg_datapath #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .SCREEN_BITS     (SCREEN_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .seq         (seq),
      .random_word (req_bus.random_word),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .pixel_x     (rsp_bus.pixel_x),
      .pixel_y     (rsp_bus.pixel_y),
      .map_chosen  (rsp_bus.map_chosen),
      .clipped     (rsp_bus.clipped)
   );

endmodule

// ===== sv/ifscg_checker.sv =====
module ifscg_checker
   import ifscg_pkg::*;
   #(
   parameter int SCREEN_BITS = 10
   ) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SCREEN_BITS-1:0] rsp_pixel_x,
   input logic [SCREEN_BITS-1:0] rsp_pixel_y,
   input logic [MAP_BITS-1:0]    rsp_map_chosen,
   input logic                   rsp_clipped
);

   logic req_accept;

   assign req_accept = req_valid && req_ready;

   // The program runs for several steps after a request, so it cannot take another at once.
   assert property (@(posedge clock) disable iff (reset) req_accept |=> !req_ready)
      else $error("request accepted in the cycle right after an accepted request");

   // A response never becomes valid in the cycle right after its request was taken.
   assert property (@(posedge clock) disable iff (reset) $rose(rsp_valid) |-> !$past(req_accept))
      else $error("response appeared one cycle after a request");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)
         && $stable(rsp_map_chosen) && $stable(rsp_clipped))
      else $error("stalled response changed or dropped");

endmodule

bind ifs_chaos_game_point_step_unit ifscg_checker #(
   .SCREEN_BITS (SCREEN_BITS)
) u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_pixel_x    (rsp_bus.pixel_x),
   .rsp_pixel_y    (rsp_bus.pixel_y),
   .rsp_map_chosen (rsp_bus.map_chosen),
   .rsp_clipped    (rsp_bus.clipped)
);

// ===== tb/ifs_chaos_game_point_step_unit_test.sv =====
module ifs_chaos_game_point_step_unit_test;
   import ifscg_pkg::*;

   localparam int FRAC        = 16;
   localparam int SCREEN      = 10;
   localparam int PIX_MAX     = (1 << SCREEN) - 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 300;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 60;

   typedef struct packed {
      logic [SCREEN-1:0]   px;
      logic [SCREEN-1:0]   py;
      logic [MAP_BITS-1:0] map;
      logic                clip;
   } pixel_result_type;

   typedef enum logic {
      ROW_REQ,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      csr_index_type        reg_index;
      logic [WORD_BITS-1:0] word;
      logic                 typed;
      pixel_result_type     want;
   } stim_row_type;

   function automatic stim_row_type row_req(input logic [WORD_BITS-1:0] w);
      return '{ROW_REQ, CSR_FRACTAL_SELECT, w, 1'b0, '0};
   endfunction

   function automatic stim_row_type row_typed(input logic [WORD_BITS-1:0] w,
                                              input int px, input int py,
                                              input int map, input int clip);
      pixel_result_type r;
      r = '{SCREEN'(px), SCREEN'(py), MAP_BITS'(map), 1'(clip)};
      return '{ROW_REQ, CSR_FRACTAL_SELECT, w, 1'b1, r};
   endfunction

   function automatic stim_row_type row_csr(input csr_index_type idx,
                                            input logic [CSR_DATA_BITS-1:0] data);
      return '{ROW_CSR, idx, WORD_BITS'(data), 1'b0, '0};
   endfunction

   localparam int DIRECTED_ROWS = 33;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      row_typed(32'h0000_0000, 400, 600, 0, 0),
      row_typed(32'h0000_0000, 400, 600, 0, 0),
      row_req(32'd42949672),
      row_req(32'd42949673),
      row_req(32'd3693671873),
      row_req(32'd3693671874),
      row_req(32'd3994319584),
      row_req(32'd3994319585),
      row_req(32'hFFFF_FFFF),
      row_req(32'h8000_0000),
      row_csr(CSR_FRACTAL_SELECT, 10'h3FE),
      row_csr(CSR_PIXEL_SCALE, 10'h3FF),
      row_csr(CSR_X_ORIGIN, 10'd0),
      row_csr(CSR_Y_ORIGIN, 10'd1023),
      row_req(32'hFFFF_FFFF),
      row_req(32'd1431512599),
      row_req(32'd1431512600),
      row_req(32'd2863025198),
      row_req(32'd2863025199),
      row_req(32'h5555_5555),
      row_req(32'hAAAA_AAAA),
      row_csr(CSR_PIXEL_SCALE, 10'd0),
      row_csr(CSR_X_ORIGIN, 10'd1023),
      row_csr(CSR_Y_ORIGIN, 10'd0),
      row_csr(CSR_FRACTAL_SELECT, 10'd1),
      row_typed(32'h0000_0000, 1023, 0, 0, 0),
      row_typed(32'hFFFF_FFFF, 1023, 0, 3, 0),
      row_csr(CSR_PIXEL_SCALE, 10'h0FF),
      row_req(32'h1234_5678),
      row_req(32'hDEAD_BEEF),
      row_req(32'h0F0F_0F0F),
      row_req(32'h0000_0000),
      row_req(32'hFFFF_FFFF)
   };

   logic clock;
   logic reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   ifscg_req_if req_bus ();
   ifscg_rsp_if #(.SCREEN_BITS(SCREEN)) rsp_bus ();

   ifs_chaos_game_point_step_unit #(
      .COORD_FRAC_BITS(FRAC),
      .SCREEN_BITS(SCREEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   logic                   cfg_fern  = FRACTAL_SELECT_RESET;
   logic [SCALE_BITS-1:0]  cfg_scale = PIXEL_SCALE_RESET;
   logic [ORIGIN_BITS-1:0] cfg_x_org = X_ORIGIN_RESET;
   logic [ORIGIN_BITS-1:0] cfg_y_org = Y_ORIGIN_RESET;
   longint                 point_x   = 0;
   longint                 point_y   = 0;

   pixel_result_type pending_pixels [$];
   int  failures        = 0;
   int  cycle_count     = 0;
   int  send_idle_max   = 0;
   int  rsp_idle_max    = 0;
   bit  offering        = 0;
   bit  csr_active      = 0;
   bit  hold_rsp_pending = 0;

   function automatic longint to_q16(input longint per10k);
      return ((per10k <<< FRAC) + 64'sd5000) / 64'sd10000;
   endfunction

   function automatic longint unsigned map_boundary(input longint unsigned per10k);
      return (per10k * 64'hFFFF_FFFF + 64'd9999) / 64'd10000;
   endfunction

   function automatic longint affine_round(input longint p, input longint q);
      return (p * point_x + q * point_y + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint clamp_coord(input longint v);
      longint hi;
      hi = (64'sd1 <<< (FRAC + 7)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint clamp_pixel(input longint v, inout logic clip);
      if (v < 0) begin
         clip = 1'b1;
         return 0;
      end
      if (v > PIX_MAX) begin
         clip = 1'b1;
         return PIX_MAX;
      end
      return v;
   endfunction

   function automatic pixel_result_type advance_point(input logic [WORD_BITS-1:0] w);
      longint a, b, c, d, e, f, nx, ny, px, py, sc, xo, yo, half;
      logic [MAP_BITS-1:0] k;
      logic clip;
      pixel_result_type r;
      a = 0; b = 0; c = 0; d = 0; e = 0; f = 0;
      k = '0;
      clip = 1'b0;
      if (cfg_fern) begin
         if (w >= map_boundary(9300)) k = 2'd3;
         else if (w >= map_boundary(8600)) k = 2'd2;
         else if (w >= map_boundary(100)) k = 2'd1;
         case (k)
            2'd0: d = to_q16(1600);
            2'd1: begin
               a = to_q16(8500); b = to_q16(400); c = -to_q16(400); d = to_q16(8500);
               f = to_q16(16000);
            end
            2'd2: begin
               a = to_q16(2000); b = -to_q16(2600); c = to_q16(2300); d = to_q16(2200);
               f = to_q16(16000);
            end
            default: begin
               a = -to_q16(1500); b = to_q16(2800); c = to_q16(2600); d = to_q16(2400);
               f = to_q16(4400);
            end
         endcase
      end else begin
         if (w >= map_boundary(6666)) k = 2'd2;
         else if (w >= map_boundary(3333)) k = 2'd1;
         a = to_q16(5000);
         d = to_q16(5000);
         case (k)
            2'd0: f = to_q16(50000);
            2'd1: e = -to_q16(28850);
            default: e = to_q16(28850);
         endcase
      end
      nx = clamp_coord(affine_round(a, b) + e);
      ny = clamp_coord(affine_round(c, d) + f);
      point_x = nx;
      point_y = ny;
      sc = cfg_scale;
      xo = cfg_x_org;
      yo = cfg_y_org;
      half = 64'sd1 <<< (FRAC - 1);
      px = clamp_pixel((sc * nx + (xo <<< FRAC) + half) >>> FRAC, clip);
      py = clamp_pixel(((yo <<< FRAC) + half - sc * ny) >>> FRAC, clip);
      r.px = SCREEN'(px);
      r.py = SCREEN'(py);
      r.map = k;
      r.clip = clip;
      return r;
   endfunction

   task automatic push_word(input logic [WORD_BITS-1:0] w, input bit forced,
                            input pixel_result_type forced_result);
      int gap;
      pixel_result_type predicted;
      gap = $urandom_range(0, send_idle_max);
      if (gap > 0) begin
         if (offering) req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.random_word <= w;
      offering = 1;
      do @(posedge clock); while (!req_bus.ready);
      predicted = advance_point(w);
      pending_pixels.push_back(forced ? forced_result : predicted);
   endtask

   task automatic drain_results();
      if (offering) begin
         req_bus.valid <= 1'b0;
         offering = 0;
      end
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      csr_active = 1;
      @(posedge clock);
      case (idx)
         CSR_FRACTAL_SELECT: cfg_fern = data[0];
         CSR_PIXEL_SCALE:    cfg_scale = data[SCALE_BITS-1:0];
         CSR_X_ORIGIN:       cfg_x_org = data[ORIGIN_BITS-1:0];
         CSR_Y_ORIGIN:       cfg_y_org = data[ORIGIN_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      if (csr_active) begin
         csr_write_enable <= 1'b0;
         csr_active = 0;
      end
   endtask

   function automatic logic [ORIGIN_BITS-1:0] pick_origin();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return ORIGIN_BITS'($urandom_range(0, PIX_MAX));
      endcase
   endfunction

   function automatic logic [WORD_BITS-1:0] pick_word();
      longint unsigned edge_pos;
      if ($urandom_range(0, 9) < 2) begin
         case ($urandom_range(0, 4))
            0: edge_pos = map_boundary(100);
            1: edge_pos = map_boundary(8600);
            2: edge_pos = map_boundary(9300);
            3: edge_pos = map_boundary(3333);
            default: edge_pos = map_boundary(6666);
         endcase
         return WORD_BITS'(edge_pos + $urandom_range(0, 6) - 3);
      end
      return $urandom;
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** ifs_chaos_game_point_step_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      pixel_result_type got, want;
      bit ready_on;
      int gap;
      ready_on = 0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp_pending) begin
            if (ready_on) rsp_bus.ready <= 1'b0;
            ready_on = 0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp_pending = 0;
         end
         gap = $urandom_range(0, rsp_idle_max);
         if (gap > 0) begin
            if (ready_on) rsp_bus.ready <= 1'b0;
            ready_on = 0;
            repeat (gap) @(posedge clock);
         end
         if (!ready_on) rsp_bus.ready <= 1'b1;
         ready_on = 1;
         do @(posedge clock); while (!rsp_bus.valid);
         got = '{rsp_bus.pixel_x, rsp_bus.pixel_y, rsp_bus.map_chosen, rsp_bus.clipped};
         if (pending_pixels.size() == 0) begin
            $error("response with no request outstanding: pixel_x %0d pixel_y %0d",
                   got.px, got.py);
            failures++;
         end else begin
            want = pending_pixels.pop_front();
            if (got.px !== want.px) begin
               $error("pixel_x: expected %0d, got %0d", want.px, got.px);
               failures++;
            end
            if (got.py !== want.py) begin
               $error("pixel_y: expected %0d, got %0d", want.py, got.py);
               failures++;
            end
            if (got.map !== want.map) begin
               $error("map_chosen: expected %0d, got %0d", want.map, got.map);
               failures++;
            end
            if (got.clip !== want.clip) begin
               $error("clipped: expected %0d, got %0d", want.clip, got.clip);
               failures++;
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      logic [SCALE_BITS-1:0] scale;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.random_word <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_FRACTAL_SELECT;
      csr_write_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_max = 2;
      rsp_idle_max = 2;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED[i];
         if (row.kind == ROW_CSR) begin
            if (!csr_active) drain_results();
            write_reg(row.reg_index, row.word[CSR_DATA_BITS-1:0]);
         end else begin
            end_writes();
            push_word(row.word, row.typed, row.want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         case (phase)
            0: scale = 8'd0;
            1: scale = 8'd255;
            default: scale = ($urandom_range(0, 2) == 0) ? SCALE_BITS'($urandom)
                                                          : SCALE_BITS'($urandom_range(30, 120));
         endcase
         write_reg(CSR_FRACTAL_SELECT, CSR_DATA_BITS'($urandom_range(0, PIX_MAX)));
         write_reg(CSR_PIXEL_SCALE, {2'($urandom_range(0, 3)), scale});
         write_reg(CSR_X_ORIGIN, pick_origin());
         write_reg(CSR_Y_ORIGIN, pick_origin());
         end_writes();
         send_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
         rsp_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
         if (phase == 3) hold_rsp_pending = 1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 5 && n == PHASE_ITEMS / 2) drain_results();
            push_word(pick_word(), 1'b0, '0);
         end
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (failures == 0) begin
         $display("** ifs_chaos_game_point_step_unit: PASSED **");
      end else begin
         $display("** ifs_chaos_game_point_step_unit: FAILED **");
      end
      $finish;
   end

endmodule
